// File: rtl/bba_pkg.sv
// Package for the bitmap block allocator: widths, request kinds, status codes
// and the structs passed between the allocator modules.
// Depends on nothing.
`default_nettype none

package bba_pkg;

	localparam int MAX_BLOCKS = 4096;
	localparam int WORD_BITS  = 64;
	localparam int MAP_WORDS  = MAX_BLOCKS / WORD_BITS;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int ADDR_W     = $clog2(MAP_WORDS);
	localparam int IDX_W      = BIT_W + ADDR_W;
	localparam int CNT_W      = IDX_W + 1;

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_MARK  = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_NOSPACE  = 2'd2;
	localparam logic [1:0] ST_CONFLICT = 2'd3;

	typedef struct packed {
		logic                 en;
		logic [ADDR_W-1:0]    addr;
		logic [WORD_BITS-1:0] data;
	} map_wr_t;

	typedef struct packed {
		logic             full;
		logic [BIT_W-1:0] pos;
	} ffz_t;

endpackage

`default_nettype wire

// File: rtl/bba_map.sv
// Usage bitmap store: one word memory with a registered read port and a
// valid bit per word so that a reset or clear takes effect at once.
// Depends on bba_pkg.
`default_nettype none

module bba_map (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           clr,
	input  wire bba_pkg::map_wr_t               wr,
	input  wire logic [bba_pkg::ADDR_W-1:0]     rd_addr,
	output logic      [bba_pkg::WORD_BITS-1:0]  rd_data
);

	logic [bba_pkg::WORD_BITS-1:0] mem [bba_pkg::MAP_WORDS];
	logic [bba_pkg::MAP_WORDS-1:0] valid_q;
	logic [bba_pkg::WORD_BITS-1:0] rd_raw_q;
	logic                          rd_ok_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_raw_q <= mem[rd_addr];
		rd_ok_q  <= valid_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	assign rd_data = rd_ok_q ? rd_raw_q : '0;

endmodule

`default_nettype wire

// File: rtl/bba_ffz.sv
// Find-first-zero unit: reports whether a bitmap word is full and, if not,
// the position of its lowest clear bit.
// Depends on bba_pkg.
`default_nettype none

module bba_ffz (
	input  wire logic [bba_pkg::WORD_BITS-1:0] word,
	output bba_pkg::ffz_t                      res
);

	always_comb begin
		res.full = &word;
		res.pos  = '0;
		for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				res.pos = bba_pkg::BIT_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/bitmap_block_allocator_unit.sv
// Bitmap block allocator top level: request sequencer, block limit register,
// used count and result register.
// Depends on bba_pkg, bba_map and bba_ffz.
//
// Channel  Dir  Signals                       Content
// s_       in   tvalid tready tdata tuser     request beat
// m_       out  tvalid tready tdata tuser     result beat
// cfg_     in   wr_en wr_data                 total_blocks register
//
// A clear, or a free or mark with an out-of-range index, goes from idle straight to done.
// A valid free or mark passes through the read and evaluate states: one memory read, one update.
// An allocate passes through the read and evaluate states once per bitmap word visited,
// as set by the single read port and the shared find-first-zero unit.
// Reset clears the map at once through per-word valid bits; no sweep is needed.
// A finished result waits in the output register while the next request is
// taken; the sequencer stalls only when that register is still full.
`default_nettype none

module bitmap_block_allocator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // block_index[11:0], zero pad
	input  wire logic [1:0]  s_tuser,   // kind[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // alloc_block[11:0], used_count[24:12], zero pad
	output logic      [1:0]  m_tuser,   // status[1:0]
	input  wire logic        cfg_wr_en,
	input  wire logic [12:0] cfg_wr_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_EVAL = 3'd2;
	localparam logic [2:0] S_DONE = 3'd3;

	localparam int IW = bba_pkg::IDX_W;
	localparam int CW = bba_pkg::CNT_W;
	localparam int AW = bba_pkg::ADDR_W;
	localparam int BW = bba_pkg::BIT_W;
	localparam logic [CW-1:0] MAX_LIM = CW'(bba_pkg::MAX_BLOCKS);

	logic [2:0]    state_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] used_q;
	logic [1:0]    kind_q;
	logic [IW-1:0] idx_q;
	logic [AW-1:0] word_q;
	logic [1:0]    res_status_q;
	logic [IW-1:0] res_alloc_q;
	logic          m_valid_q;
	logic [1:0]    m_status_q;
	logic [IW-1:0] m_alloc_q;
	logic [CW-1:0] m_used_q;

	logic [CW-1:0]                 limit;
	logic                          accept;
	logic [IW-1:0]                 in_idx;
	logic                          clr;
	bba_pkg::map_wr_t              wr;
	logic [bba_pkg::WORD_BITS-1:0] word;
	bba_pkg::ffz_t                 ffz;
	logic [IW-1:0]                 cand;
	logic [AW:0]                   next_word;
	logic [CW-1:0]                 next_base;
	logic                          use_bit;
	logic                          cur_bit;
	logic                          out_free;

	assign limit     = (total_q > MAX_LIM) ? MAX_LIM : total_q;
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign in_idx    = s_tdata[IW-1:0];
	assign clr       = accept && (s_tuser == bba_pkg::KIND_CLEAR);
	assign cand      = {word_q, ffz.pos};
	assign next_word = {1'b0, word_q} + (AW+1)'(1);
	assign next_base = {next_word, {BW{1'b0}}};
	assign use_bit   = (kind_q == bba_pkg::KIND_MARK);
	assign cur_bit   = word[idx_q[BW-1:0]];
	assign out_free  = !m_valid_q || m_tready;

	bba_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (clr),
		.wr      (wr),
		.rd_addr (word_q),
		.rd_data (word)
	);

	bba_ffz u_ffz (
		.word (word),
		.res  (ffz)
	);

	always_comb begin
		wr.en   = 1'b0;
		wr.addr = word_q;
		wr.data = word;
		if (state_q == S_EVAL) begin
			if (kind_q == bba_pkg::KIND_ALLOC) begin
				if (!ffz.full && ({1'b0, cand} < limit)) begin
					wr.en   = 1'b1;
					wr.data = word | (bba_pkg::WORD_BITS'(1) << ffz.pos);
				end
			end else if (cur_bit != use_bit) begin
				wr.en = 1'b1;
				if (use_bit) begin
					wr.data = word | (bba_pkg::WORD_BITS'(1) << idx_q[BW-1:0]);
				end else begin
					wr.data = word & ~(bba_pkg::WORD_BITS'(1) << idx_q[BW-1:0]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= MAX_LIM;
			used_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				total_q <= cfg_wr_data;
			end
			if ((state_q == S_DONE) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_tuser == bba_pkg::KIND_CLEAR) begin
							used_q  <= '0;
							state_q <= S_DONE;
						end else if (s_tuser == bba_pkg::KIND_ALLOC) begin
							state_q <= (limit == '0) ? S_DONE : S_READ;
						end else begin
							state_q <= ({1'b0, in_idx} >= limit) ? S_DONE : S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (kind_q == bba_pkg::KIND_ALLOC) begin
						if (ffz.full) begin
							state_q <= (next_base >= limit) ? S_DONE : S_READ;
						end else begin
							state_q <= S_DONE;
							if ({1'b0, cand} < limit) begin
								used_q <= used_q + CW'(1);
							end
						end
					end else begin
						state_q <= S_DONE;
						if (cur_bit != use_bit) begin
							used_q <= use_bit ? used_q + CW'(1) : used_q - CW'(1);
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				kind_q      <= s_tuser;
				idx_q       <= in_idx;
				word_q      <= (s_tuser == bba_pkg::KIND_ALLOC) ? '0 : in_idx[IW-1:BW];
				res_alloc_q <= '0;
				if (s_tuser == bba_pkg::KIND_CLEAR) begin
					res_status_q <= bba_pkg::ST_OK;
				end else if (s_tuser == bba_pkg::KIND_ALLOC) begin
					res_status_q <= bba_pkg::ST_NOSPACE;
				end else begin
					res_status_q <= bba_pkg::ST_RANGE;
				end
			end
			S_READ: begin
			end
			S_EVAL: begin
				if (kind_q == bba_pkg::KIND_ALLOC) begin
					if (ffz.full) begin
						word_q       <= next_word[AW-1:0];
						res_status_q <= bba_pkg::ST_NOSPACE;
					end else if ({1'b0, cand} < limit) begin
						res_status_q <= bba_pkg::ST_OK;
						res_alloc_q  <= cand;
					end else begin
						res_status_q <= bba_pkg::ST_NOSPACE;
					end
				end else begin
					res_status_q <= (cur_bit != use_bit) ? bba_pkg::ST_OK : bba_pkg::ST_CONFLICT;
				end
			end
			S_DONE: begin
				if (out_free) begin
					m_status_q <= res_status_q;
					m_alloc_q  <= res_alloc_q;
					m_used_q   <= used_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {{(32 - IW - CW){1'b0}}, m_used_q, m_alloc_q};

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= MAX_LIM)
		else $error("used count above capacity");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> (used_q == '0))
		else $error("clear did not zero the used count");

	a_alloc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != bba_pkg::ST_OK)) |-> (m_alloc_q == '0))
		else $error("failed request carries a block index");

	a_write_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == S_EVAL))
		else $error("bitmap written outside the update step");

endmodule

`default_nettype wire

// File: tb/sv/tb_bitmap_block_allocator_unit.sv
// Self-checking testbench for bitmap_block_allocator_unit: a directed table, then random
// phases at several block limits, checked against a bitmap predictor held here.
// Depends on bba_pkg and the allocator RTL.
`default_nettype none

module tb_bitmap_block_allocator_unit;
	import bba_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] blk;
		logic [12:0] count;
	} alloc_res_t;

	typedef struct {
		bit          cfg;
		logic [1:0]  kind;
		logic [12:0] val;
		bit          typed;
		logic [1:0]  st;
		logic [11:0] blk;
		logic [12:0] cnt;
	} dir_row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_wr_en;
	logic [12:0] cfg_wr_data;

	logic       req_typed;
	alloc_res_t req_expect;

	bit [MAX_BLOCKS-1:0] map_bits;
	logic [12:0]         used_cnt;
	logic [12:0]         limit_reg;
	alloc_res_t          owed_results [$];
	int                  err_count;
	int                  burst_left;
	bit                  long_hold_req;

	// Rows with a typed expectation are checked against it; the others against the predictor.
	dir_row_t dir_rows [31] = '{
		'{0, KIND_ALLOC, 13'd0,     1, ST_OK,       12'd0, 13'd1},
		'{0, KIND_ALLOC, 13'hFFF,   1, ST_OK,       12'd1, 13'd2},
		'{0, KIND_FREE,  13'd0,     1, ST_OK,       12'd0, 13'd1},
		'{0, KIND_FREE,  13'd0,     1, ST_CONFLICT, 12'd0, 13'd1},
		'{0, KIND_MARK,  13'd4095,  1, ST_OK,       12'd0, 13'd2},
		'{0, KIND_MARK,  13'd4095,  1, ST_CONFLICT, 12'd0, 13'd2},
		'{0, KIND_FREE,  13'd4095,  1, ST_OK,       12'd0, 13'd1},
		'{0, KIND_ALLOC, 13'd0,     1, ST_OK,       12'd0, 13'd2},
		'{0, KIND_MARK,  13'd2,     1, ST_OK,       12'd0, 13'd3},
		'{0, KIND_ALLOC, 13'd0,     1, ST_OK,       12'd3, 13'd4},
		'{0, KIND_MARK,  13'hAAA,   0, ST_OK,       12'd0, 13'd0},
		'{0, KIND_MARK,  13'h555,   0, ST_OK,       12'd0, 13'd0},
		'{0, KIND_FREE,  13'h800,   1, ST_CONFLICT, 12'd0, 13'd6},
		'{0, KIND_CLEAR, 13'hFFF,   1, ST_OK,       12'd0, 13'd0},
		'{1, KIND_ALLOC, 13'd3,     0, ST_OK,       12'd0, 13'd0},
		'{0, KIND_FREE,  13'd3,     1, ST_RANGE,    12'd0, 13'd0},
		'{0, KIND_MARK,  13'd4095,  1, ST_RANGE,    12'd0, 13'd0},
		'{0, KIND_ALLOC, 13'd0,     1, ST_OK,       12'd0, 13'd1},
		'{0, KIND_ALLOC, 13'd0,     1, ST_OK,       12'd1, 13'd2},
		'{0, KIND_ALLOC, 13'd0,     1, ST_OK,       12'd2, 13'd3},
		'{0, KIND_ALLOC, 13'd0,     1, ST_NOSPACE,  12'd0, 13'd3},
		'{1, KIND_ALLOC, 13'd0,     0, ST_OK,       12'd0, 13'd0},
		'{0, KIND_ALLOC, 13'd0,     1, ST_NOSPACE,  12'd0, 13'd3},
		'{0, KIND_FREE,  13'd0,     1, ST_RANGE,    12'd0, 13'd3},
		'{1, KIND_ALLOC, 13'd8191,  0, ST_OK,       12'd0, 13'd0},
		'{0, KIND_MARK,  13'd4095,  1, ST_OK,       12'd0, 13'd4},
		'{0, KIND_ALLOC, 13'd0,     1, ST_OK,       12'd3, 13'd5},
		'{1, KIND_ALLOC, 13'd1,     0, ST_OK,       12'd0, 13'd0},
		'{0, KIND_FREE,  13'd1,     1, ST_RANGE,    12'd0, 13'd5},
		'{0, KIND_ALLOC, 13'd0,     1, ST_NOSPACE,  12'd0, 13'd5},
		'{0, KIND_CLEAR, 13'd0,     1, ST_OK,       12'd0, 13'd0}
	};

	int phase_lim [12] = '{40, 1, 70, 8191, 65, 0, 4095, 130, 66, 64, 4096, -1};

	bitmap_block_allocator_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	function automatic alloc_res_t bitmap_request(logic [1:0] kind, logic [11:0] idx);
		alloc_res_t  r;
		int unsigned lim;
		lim = (limit_reg > MAX_BLOCKS) ? MAX_BLOCKS : limit_reg;
		r = '0;
		case (kind)
		KIND_ALLOC: begin
			r.status = ST_NOSPACE;
			for (int b = 0; b < lim && r.status != ST_OK; b++) begin
				if (!map_bits[b]) begin
					map_bits[b] = 1'b1;
					used_cnt = used_cnt + 13'd1;
					r.status = ST_OK;
					r.blk = b[11:0];
				end
			end
		end
		KIND_FREE, KIND_MARK: begin
			if (idx >= lim) begin
				r.status = ST_RANGE;
			end else if (map_bits[idx] == (kind == KIND_MARK)) begin
				r.status = ST_CONFLICT;
			end else begin
				map_bits[idx] = (kind == KIND_MARK);
				used_cnt = (kind == KIND_MARK) ? used_cnt + 13'd1 : used_cnt - 13'd1;
				r.status = ST_OK;
			end
		end
		default: begin
			map_bits = '0;
			used_cnt = '0;
			r.status = ST_OK;
		end
		endcase
		r.count = used_cnt;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("bitmap_block_allocator_unit verification failed");
		$finish;
	end

	// Results are retired before the request beat of the same edge is predicted.
	always @(posedge clk) begin : scoreboard
		alloc_res_t want;
		alloc_res_t got;
		if (arst_n) begin
			if (cfg_wr_en)
				limit_reg = cfg_wr_data;
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[11:0], m_tdata[24:12]};
				if (owed_results.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result beat: status %0d block %0d count %0d",
						$time, got.status, got.blk, got.count);
				end else begin
					want = owed_results.pop_front();
					if (got.status !== want.status) begin
						err_count++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, got.status);
					end
					if (got.blk !== want.blk) begin
						err_count++;
						$display("%0t: alloc_block expected %0d actual %0d",
							$time, want.blk, got.blk);
					end
					if (got.count !== want.count) begin
						err_count++;
						$display("%0t: used_count expected %0d actual %0d",
							$time, want.count, got.count);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want = bitmap_request(s_tuser, s_tdata[11:0]);
				if (req_typed)
					want = req_expect;
				owed_results.push_back(want);
			end
		end
	end

	initial begin : sink
		rx_mode_t mode;
		int       span;
		int       hold;
		m_tready <= 1'b0;
		mode = RX_OPEN;
		span = 0;
		hold = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = 400;
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else begin
				if (span == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					span = $urandom_range(8, 60);
				end
				span--;
				case (mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:   m_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
			@(posedge clk);
		end
	end

	task automatic send_item(logic [1:0] kind, logic [11:0] idx, bit typed, alloc_res_t exp);
		int gap;
		s_tvalid   <= 1'b1;
		s_tuser    <= kind;
		s_tdata    <= {4'b0, idx};
		req_typed  <= typed;
		req_expect <= exp;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (owed_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(logic [12:0] value);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin : stimulus
		int          lim;
		int          eff;
		int          span;
		int          sel;
		int          pick;
		int          waited;
		logic [1:0]  kind;
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= KIND_ALLOC;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		req_typed   <= 1'b0;
		req_expect  <= '0;
		map_bits = '0;
		used_cnt = '0;
		limit_reg = 13'd4096;
		err_count = 0;
		burst_left = 5;
		long_hold_req = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg)
				write_limit(dir_rows[i].val);
			else
				send_item(dir_rows[i].kind, dir_rows[i].val[11:0], dir_rows[i].typed,
					{dir_rows[i].st, dir_rows[i].blk, dir_rows[i].cnt});
		end

		foreach (phase_lim[p]) begin
			lim = (phase_lim[p] < 0) ? $urandom_range(2, 100) : phase_lim[p];
			write_limit(lim[12:0]);
			eff = (lim > MAX_BLOCKS) ? MAX_BLOCKS : lim;
			span = eff + eff / 4 + 1;
			if (span > MAX_BLOCKS - 1)
				span = MAX_BLOCKS - 1;
			// Hold the result side off while requests keep coming, so the input backs up.
			if (p == 3) begin
				long_hold_req = 1'b1;
				burst_left = 200;
			end
			for (int n = 0; n < 62; n++) begin
				if (p == 5 && n == 31)
					settle();
				sel = $urandom_range(0, 99);
				kind = (sel < 48) ? KIND_ALLOC : (sel < 73) ? KIND_FREE :
					(sel < 98) ? KIND_MARK : KIND_CLEAR;
				sel = $urandom_range(0, 9);
				pick = (sel < 6) ? $urandom_range(0, span) : $urandom_range(0, MAX_BLOCKS - 1);
				// Steer frees towards used blocks and marks towards free ones.
				if (sel >= 8 && (kind == KIND_FREE || kind == KIND_MARK)) begin
					pick = $urandom_range(0, span);
					for (int j = 0; j < 64 && map_bits[pick] != (kind == KIND_FREE); j++)
						pick = (pick + 1) % MAX_BLOCKS;
				end
				send_item(kind, pick[11:0], 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		waited = 0;
		while (owed_results.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (150) @(posedge clk);
		if (owed_results.size() != 0) begin
			err_count++;
			$display("%0t: %0d expected results never arrived", $time, owed_results.size());
		end
		if (err_count == 0)
			$display("bitmap_block_allocator_unit verification clean");
		else
			$display("bitmap_block_allocator_unit verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: bitmap_block_allocator_unit.f
rtl/bba_pkg.sv
rtl/bba_map.sv
rtl/bba_ffz.sv
rtl/bitmap_block_allocator_unit.sv
tb/sv/tb_bitmap_block_allocator_unit.sv
